@@ design/auf_pkg.sv @@
// Shared types and constants for the advertising service identifier filter.
package auf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned UuidW    = 64;
  localparam int unsigned ChunkLen = 16;
  localparam int unsigned ChunkIdxW = $clog2(ChunkLen);
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CFG_UUID_LOW  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_UUID_HIGH = 1'd1;

  localparam logic [ByteW-1:0] AD_TYPE_UUID128_PART = 8'h06;
  localparam logic [ByteW-1:0] AD_TYPE_UUID128_ALL  = 8'h07;

  typedef struct packed {
    logic [ByteW-1:0] adv_byte;
    logic             last_byte;
  } auf_item_t;

  typedef struct packed {
    logic valid;
    logic found;
  } auf_result_t;

endpackage

@@ design/auf_in_reg.sv @@
// Input request register of the service identifier filter.
module auf_in_reg
  import auf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,  // [7:0] adv_byte
  input  logic                 s_axis_tlast,  // last_byte
  input  logic                 take_i,
  output logic                 item_valid_o,
  output auf_item_t            item_o
);

  logic      valid_q, valid_d;
  auf_item_t item_q;

  assign s_axis_tready = !valid_q || take_i;
  assign valid_d       = s_axis_tvalid || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.adv_byte  <= s_axis_tdata;
      item_q.last_byte <= s_axis_tlast;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ design/auf_parser.sv @@
// Length-type-data walker and 128-bit identifier chunk compare.
module auf_parser
  import auf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [UuidW-1:0]     cfg_data_i,
  input  logic                 item_valid_i,
  input  auf_item_t            item_i,
  input  logic                 out_free_i,
  output logic                 take_o,
  output auf_result_t          result_o
);

  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_TYPE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  logic [UuidW-1:0]     uuid_low_q, uuid_high_q;
  logic [1:0]           phase_q, phase_d;
  logic [ByteW-1:0]     left_q, left_d;
  logic                 list_q, list_d;
  logic [ChunkIdxW-1:0] idx_q, idx_d;
  logic                 mis_q, mis_d;
  logic                 shit_q, shit_d;
  logic                 phit_q, phit_d;
  logic [2*UuidW-1:0]   uuid;
  logic [ByteW-1:0]     exp_byte;
  logic                 mis_now;
  logic [ByteW-1:0]     b;

  assign b        = item_i.adv_byte;
  assign uuid     = {uuid_high_q, uuid_low_q};
  assign exp_byte = uuid[idx_q*ByteW +: ByteW];
  assign mis_now  = mis_q || (b != exp_byte);
  assign take_o   = item_valid_i && (!item_i.last_byte || out_free_i);

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    list_d  = list_q;
    idx_d   = idx_q;
    mis_d   = mis_q;
    shit_d  = shit_q;
    phit_d  = phit_q;
    case (phase_q)
      PH_LENGTH: begin
        if (!item_i.last_byte) begin
          if (b == '0) begin
            phase_d = PH_STOP;
          end else begin
            left_d  = b;
            phase_d = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        left_d  = left_q - 1'b1;
        list_d  = (b == AD_TYPE_UUID128_PART) || (b == AD_TYPE_UUID128_ALL);
        idx_d   = '0;
        mis_d   = 1'b0;
        shit_d  = 1'b0;
        phase_d = PH_DATA;
        if (left_d == '0) begin
          phase_d = PH_LENGTH;
        end
      end
      PH_DATA: begin
        mis_d = mis_now;
        if (idx_q == ChunkIdxW'(ChunkLen - 1)) begin
          if (list_q && !mis_now) begin
            shit_d = 1'b1;
          end
          mis_d = 1'b0;
        end
        idx_d  = idx_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_d == '0) begin
          phit_d  = phit_q || shit_d;
          phase_d = PH_LENGTH;
        end
      end
      default: begin
      end
    endcase
    result_o.valid = take_o && item_i.last_byte;
    result_o.found = phit_d;
    if (item_i.last_byte) begin
      phase_d = PH_LENGTH;
      left_d  = '0;
      list_d  = 1'b0;
      idx_d   = '0;
      mis_d   = 1'b0;
      shit_d  = 1'b0;
      phit_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_low_q  <= '0;
      uuid_high_q <= '0;
      phase_q     <= PH_LENGTH;
      left_q      <= '0;
      list_q      <= 1'b0;
      idx_q       <= '0;
      mis_q       <= 1'b0;
      shit_q      <= 1'b0;
      phit_q      <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_UUID_LOW) begin
        uuid_low_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_UUID_HIGH) begin
        uuid_high_q <= cfg_data_i;
      end
      if (take_o) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        list_q  <= list_d;
        idx_q   <= idx_d;
        mis_q   <= mis_d;
        shit_q  <= shit_d;
        phit_q  <= phit_d;
      end
    end
  end

endmodule

@@ design/auf_out_reg.sv @@
// Result register of the service identifier filter.
module auf_out_reg
  import auf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  auf_result_t      result_i,
  output logic             out_free_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata   // [0] found, [7:1] zero
);

  logic valid_q, valid_d;
  logic found_q;

  assign out_free_o = !valid_q || m_axis_tready;
  assign valid_d    = result_i.valid || (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      found_q <= result_i.found;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(ByteW-1){1'b0}}, found_q};

endmodule

@@ design/adv_service_uuid_filter_unit.sv @@
// Top level of the advertising payload 128-bit service identifier filter.
//
// Payload bytes enter on the s_axis request channel, one byte per request,
// with s_axis_tlast on the final byte of a payload. The block walks the
// length-type-data structures and compares each whole 16-byte chunk of
// structures of type 0x06 or 0x07 with the identifier in the two config
// registers (index 0 low half, index 1 high half), written through cfg_*.
// Exactly one result request leaves on m_axis per payload, after its last
// byte; m_axis_tdata bit 0 says whether the identifier was found.
// Throughput is one byte per cycle while m_axis does not stall. A byte
// is held in the input register and is parsed as it leaves it; the result
// appears in the output register in the following cycle.
// Reset clears the parse state, the identifier and the valid flags of both channel registers.
// When m_axis stalls with a result pending, non-last bytes keep flowing;
// the next last byte waits in the input register and s_axis_tready drops
// until the pending result is taken.
module adv_service_uuid_filter_unit
  import auf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [UuidW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,  // [7:0] adv_byte
  input  logic               s_axis_tlast,  // last_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata   // [0] found, [7:1] zero
);

  logic        take;
  logic        item_valid;
  auf_item_t   item;
  logic        out_free;
  auf_result_t result;

  auf_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  auf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .take_o       (take),
    .result_o     (result)
  );

  auf_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .result_i      (result),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for the advertising payload service identifier filter.
module testbench;
  import auf_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 250;

  typedef enum logic [1:0] {
    SEEK_LEN,
    SEEK_TYPE,
    IN_DATA,
    HALTED
  } scan_phase_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [UuidW-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata  = '0;  // [7:0] adv_byte
  logic               s_axis_tlast  = 1'b0;  // last_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;  // [0] found, [7:1] zero

  adv_service_uuid_filter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  scan_phase_e      scan_phase;
  logic [7:0]       owed;
  logic             uuid_list;
  logic [3:0]       chunk_pos;
  logic             chunk_bad;
  logic             struct_hit;
  logic             frame_hit;
  logic [UuidW-1:0] id_lo;
  logic [UuidW-1:0] id_hi;

  auf_item_t adv_q[$];
  logic      verdict_q[$];
  int        bytes_queued = 0;
  int        errors       = 0;
  int        cycles       = 0;
  int        tx_wait      = 0;
  int        rx_wait      = 0;
  bit        quiet        = 1'b0;

  function automatic void scan_reset();
    scan_phase = SEEK_LEN;
    owed       = '0;
    uuid_list  = 1'b0;
    chunk_pos  = '0;
    chunk_bad  = 1'b0;
    struct_hit = 1'b0;
    frame_hit  = 1'b0;
  endfunction

  function automatic void close_if_done();
    if (owed == 8'd0) begin
      frame_hit  = frame_hit | struct_hit;
      scan_phase = SEEK_LEN;
    end
  endfunction

  function automatic void scan_byte(input auf_item_t it);
    logic [2*UuidW-1:0] ident;
    ident = {id_hi, id_lo};
    case (scan_phase)
      SEEK_LEN: begin
        if (!it.last_byte) begin
          if (it.adv_byte == 8'd0) begin
            scan_phase = HALTED;
          end else begin
            owed       = it.adv_byte;
            scan_phase = SEEK_TYPE;
          end
        end
      end
      SEEK_TYPE: begin
        owed       = owed - 8'd1;
        uuid_list  = (it.adv_byte == AD_TYPE_UUID128_PART) ||
                     (it.adv_byte == AD_TYPE_UUID128_ALL);
        chunk_pos  = '0;
        chunk_bad  = 1'b0;
        struct_hit = 1'b0;
        scan_phase = IN_DATA;
        close_if_done();
      end
      IN_DATA: begin
        if (it.adv_byte != ident[8*chunk_pos +: 8]) chunk_bad = 1'b1;
        if (chunk_pos == 4'(ChunkLen - 1)) begin
          if (uuid_list && !chunk_bad) struct_hit = 1'b1;
          chunk_bad = 1'b0;
        end
        chunk_pos = chunk_pos + 4'd1;
        owed      = owed - 8'd1;
        close_if_done();
      end
      default: begin
      end
    endcase
    if (it.last_byte) begin
      verdict_q.push_back(frame_hit);
      scan_reset();
    end
  endfunction

  function automatic void push_frame(input logic [7:0] pl[$], input int ignored);
    for (int i = 0; i < pl.size(); i++) begin
      adv_q.push_back('{adv_byte: pl[i], last_byte: (i == pl.size() - 1)});
    end
    bytes_queued += pl.size() - ignored;
  endfunction

  function automatic void make_frame();
    logic [7:0]         pl[$];
    logic [7:0]         chunk[16];
    logic [2*UuidW-1:0] ident;
    logic [7:0]         kind;
    int                 nchunk, tail, n, cut, ignored, len;
    ident   = {id_hi, id_lo};
    ignored = 0;
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 40);
      repeat (n) pl.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: kind = AD_TYPE_UUID128_PART;
          1, 2: kind = AD_TYPE_UUID128_ALL;
          default: kind = 8'($urandom);
        endcase
        nchunk = $urandom_range(0, 2);
        tail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        pl.push_back(8'(1 + 16 * nchunk + tail));
        pl.push_back(kind);
        repeat (nchunk) begin
          for (int k = 0; k < 16; k++) chunk[k] = ident[8*k +: 8];
          case ($urandom_range(0, 3))
            2: begin
              n = $urandom_range(0, 15);
              chunk[n] = chunk[n] ^ 8'(1 << $urandom_range(0, 7));
            end
            3: for (int k = 0; k < 16; k++) chunk[k] = 8'($urandom);
            default: begin
            end
          endcase
          for (int k = 0; k < 16; k++) pl.push_back(chunk[k]);
        end
        for (int k = 0; k < tail; k++) pl.push_back(ident[8*k +: 8]);
      end
      case ($urandom_range(0, 7))
        0: begin
          len = pl.size() - 1;
          cut = $urandom_range(1, (len > 20) ? 20 : len);
          repeat (cut) void'(pl.pop_back());
        end
        1: pl.push_back(8'($urandom));
        2: begin
          pl.push_back(8'd0);
          n = $urandom_range(1, 6);
          repeat (n) pl.push_back(8'($urandom));
          ignored = n;
        end
        3: begin
          pl.push_back(8'($urandom_range(20, 255)));
          pl.push_back(AD_TYPE_UUID128_ALL);
          for (int k = 0; k < 16; k++) pl.push_back(ident[8*k +: 8]);
        end
        default: begin
        end
      endcase
    end
    push_frame(pl, ignored);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [UuidW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_UUID_LOW) id_lo = val;
    else id_hi = val;
  endtask

  task automatic set_ident(input logic [UuidW-1:0] lo, input logic [UuidW-1:0] hi);
    write_reg(CFG_UUID_LOW, lo);
    write_reg(CFG_UUID_HIGH, hi);
  endtask

  task automatic wait_drained();
    while (adv_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : byte_drv
    auf_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_wait = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) scan_byte(auf_item_t'({s_axis_tdata, s_axis_tlast}));
      if (tx_wait > 0) begin
        tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (adv_q.size() != 0) begin
        nxt = adv_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.adv_byte;
        s_axis_tlast  <= nxt.last_byte;
        tx_wait = quiet ? 0 : $urandom_range(0, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_mon
    logic want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none pending: expected none, actual %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata !== {{(ByteW-1){1'b0}}, want}) begin
            $display("%0t: found flag: expected %h, actual %h", $time,
                     {{(ByteW-1){1'b0}}, want}, m_axis_tdata);
            errors++;
          end
        end
        rx_wait = quiet ? 0 : $urandom_range(0, 7);
      end else if (m_axis_tvalid && rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("adv_service_uuid_filter_unit: mismatch");
      $finish;
    end
  end

  initial begin : stim
    logic [7:0]         pl[$];
    logic [2*UuidW-1:0] ident;
    int                 target;
    scan_reset();
    id_lo = '0;
    id_hi = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_ident({$urandom, $urandom}, {$urandom, $urandom});
    ident = {id_hi, id_lo};
    pl = '{8'h00};
    push_frame(pl, 0);
    pl = '{8'h00, 8'hff};
    push_frame(pl, 1);
    pl = '{8'h11, AD_TYPE_UUID128_PART};
    for (int k = 0; k < 16; k++) pl.push_back(ident[8*k +: 8]);
    push_frame(pl, 0);
    pl = '{8'h03, AD_TYPE_UUID128_ALL};
    push_frame(pl, 0);
    pl = '{8'h01, 8'hff, 8'hff};
    push_frame(pl, 0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_ident('1, '1);
        1: set_ident('0, '0);
        2: set_ident({$urandom, $urandom}, {56'd0, AD_TYPE_UUID128_ALL});
        default: set_ident({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      quiet  = (ph == 2);
      target = bytes_queued + PhaseBytes;
      while (bytes_queued < target) make_frame();
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("adv_service_uuid_filter_unit: match");
    end else begin
      $display("adv_service_uuid_filter_unit: mismatch");
    end
    $finish;
  end

endmodule
